[rtl/core/ple_pkg.sv]
// Package for the positional list engine: sizes, operation codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package ple_pkg;
  localparam int unsigned Depth = 64;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_INSERT     = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5,
    OP_FIND       = 3'd6,
    OP_RESIZE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
  } ple_cmd_t;

  typedef struct packed {
    logic scan_op;
    logic scan_last;
  } ple_sts_t;
endpackage

[rtl/core/ple_ctrl.sv]
// Controller state machine of the positional list engine.
// Depends on ple_pkg; drives the datapath through ple_cmd_t and reads ple_sts_t.
`timescale 1ns / 1ps
module ple_ctrl import ple_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  output logic     m_axis_tvalid,
  input  logic     m_axis_tready,
  input  ple_sts_t sts_i,
  output ple_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC: state_d = sts_i.scan_op ? ST_SCAN : ST_RESP;
      ST_SCAN: if (sts_i.scan_last) state_d = ST_RESP;
      ST_RESP: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_RESP);
    cmd_o.load    = (state_q == ST_IDLE) && s_axis_tvalid;
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.scan    = (state_q == ST_SCAN);
  end
endmodule

[rtl/core/ple_dp.sv]
// Datapath of the positional list engine: a row of shifting cells, the count and
// the result registers. Depends on ple_pkg; controlled by ple_ctrl.
`timescale 1ns / 1ps
module ple_dp import ple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ple_cmd_t          cmd_i,
  output ple_sts_t          sts_o,
  input  logic [2:0]        req_type_i,
  input  logic [CntW-1:0]   position_i,
  input  logic [WordW-1:0]  item_value_i,
  output logic              ok_o,
  output logic              found_o,
  output logic [5:0]        found_index_o,
  output logic [WordW-1:0]  read_data_o,
  output logic [6:0]        entry_count_o
);
  logic [WordW-1:0] cell_q [Depth];
  logic [CntW-1:0]  len_q, pos_q;
  logic [WordW-1:0] val_q, data_q;
  op_e              op_q;
  logic             ok_q, found_q;
  logic [IdxW-1:0]  fidx_q, scan_q;

  logic            full, ok_now, do_ins, do_rem, do_rsz;
  logic [CntW-1:0] at;

  always_comb begin
    full   = (len_q == CntW'(Depth));
    ok_now = 1'b0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rsz = 1'b0;
    at     = pos_q;
    case (op_q)
      OP_PUSH_FRONT: begin ok_now = !full; do_ins = 1'b1; at = '0; end
      OP_PUSH_BACK:  begin ok_now = !full; do_ins = 1'b1; at = len_q; end
      OP_POP_FRONT:  begin ok_now = (len_q != '0); do_rem = 1'b1; at = '0; end
      OP_INSERT:     begin ok_now = !full && (pos_q <= len_q); do_ins = 1'b1; end
      OP_REMOVE:     begin ok_now = (pos_q < len_q); do_rem = 1'b1; end
      OP_READ:       ok_now = (pos_q < len_q);
      OP_FIND:       ok_now = 1'b1;
      OP_RESIZE:     begin ok_now = (pos_q <= CntW'(Depth)); do_rsz = 1'b1; end
      default:       ok_now = 1'b0;
    endcase
  end

  // The scan rotates the whole row so that cell zero holds list index scan_q.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (cmd_i.exec && ok_now) begin
        if (do_ins) begin
          if (CntW'(i) == at) cell_q[i] <= val_q;
          else if (CntW'(i) > at) cell_q[i] <= cell_q[(i == 0) ? 0 : i - 1];
        end else if (do_rem) begin
          if (CntW'(i) >= at) cell_q[i] <= cell_q[(i == Depth - 1) ? i : i + 1];
        end else if (do_rsz) begin
          if (CntW'(i) >= len_q && CntW'(i) < pos_q) cell_q[i] <= '0;
        end
      end else if (cmd_i.scan) begin
        cell_q[i] <= cell_q[(i + 1) % Depth];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      scan_q <= '0;
    end else if (cmd_i.exec) begin
      scan_q <= '0;
      if (ok_now) begin
        if (do_ins) len_q <= len_q + 1'b1;
        else if (do_rem) len_q <= len_q - 1'b1;
        else if (do_rsz) len_q <= pos_q;
      end
    end else if (cmd_i.scan) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(req_type_i);
      pos_q   <= position_i;
      val_q   <= item_value_i;
      found_q <= 1'b0;
      fidx_q  <= '0;
      data_q  <= '0;
    end else if (cmd_i.exec) begin
      ok_q <= ok_now;
      if (ok_now && op_q == OP_POP_FRONT) data_q <= cell_q[0];
    end else if (cmd_i.scan) begin
      if (op_q == OP_READ && {1'b0, scan_q} == pos_q) data_q <= cell_q[0];
      if (op_q == OP_FIND && !found_q && {1'b0, scan_q} < len_q
          && cell_q[0] == val_q) begin
        found_q <= 1'b1;
        fidx_q  <= scan_q;
      end
    end
  end

  assign sts_o.scan_op   = ok_now && (op_q == OP_READ || op_q == OP_FIND);
  assign sts_o.scan_last = (scan_q == IdxW'(Depth - 1));

  assign ok_o          = ok_q;
  assign found_o       = found_q;
  assign found_index_o = 6'(fidx_q);
  assign read_data_o   = data_q;
  assign entry_count_o = 7'(len_q);
endmodule

[rtl/core/positional_list_engine_unit.sv]
// Top level of the positional list engine: joins controller and datapath to the streams.
// Depends on ple_pkg, ple_ctrl and ple_dp.
`timescale 1ns / 1ps
// An ordered list of up to 64 signed words. One request is taken at a time: push,
// pop, insert and remove shift the cells in parallel and resize clears any added cells,
// and their result is offered after the execute state; read and find rotate the full
// row of 64 cells past cell zero in the scan state after the execute state, and their
// result is offered when the scan ends. A failed read skips the scan. The next request
// is accepted in the cycle after the result is taken.
// A failed request leaves the list unchanged and returns ok low with zero data.
module positional_list_engine_unit import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // req_type[2:0], position[9:3], item_value[41:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // ok, found, found_index, read_data, entry_count
);
  ple_cmd_t         cmd;
  ple_sts_t         sts;
  logic             ok, found;
  logic [5:0]       fidx;
  logic [WordW-1:0] rdata;
  logic [6:0]       cnt;

  ple_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .sts_i(sts), .cmd_o(cmd)
  );

  ple_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i(s_axis_tdata[2:0]), .position_i(s_axis_tdata[9:3]),
    .item_value_i(s_axis_tdata[41:10]),
    .ok_o(ok), .found_o(found), .found_index_o(fidx), .read_data_o(rdata),
    .entry_count_o(cnt)
  );

  assign m_axis_tdata = {1'b0, cnt, rdata, fidx, found, ok};
endmodule

[rtl/core/ple_checker.sv]
// Port checker for the positional list engine, bound to the top level.
// Depends on positional_list_engine_unit only through its ports.
`timescale 1ns / 1ps
module ple_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("result too early");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[46:40] <= 7'd64) else $error("count out of range");
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[39:1] == '0)
    else $error("failed request carries data");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

[tb/positional_list_engine_unit_tb.sv]
// Self-checking testbench for the positional list engine unit: a directed table, then
// randomised requests, checked against table results or an in-bench list model. Needs ple_pkg.
`timescale 1ns / 1ps
module positional_list_engine_unit_tb import ple_pkg::*; ();

  // Members run from the top bits of the result down to bit zero.
  typedef struct packed {
    logic [6:0]  entry_count;
    logic [31:0] read_data;
    logic [5:0]  found_index;
    logic        found;
    logic        ok;
  } list_result_t;

  typedef struct {
    op_e          op;
    logic [6:0]   pos;
    logic [31:0]  val;
    bit           typed;
    list_result_t want;
  } request_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // req_type[2:0], position[9:3], item_value[41:10]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // ok, found, found_index[7:2], read_data[39:8], count[46:40]

  positional_list_engine_unit uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [31:0]  list_words [Depth];
  int           list_len = 0;
  list_result_t pending_results [$];
  int           mismatches = 0;
  int           requests_sent = 0;
  int           results_seen = 0;
  int           op_hits [8];
  logic [31:0]  value_pool [8];

  // Updates the list model for one request and returns what the block should answer.
  task automatic list_apply(input op_e op, input logic [6:0] pos, input logic [31:0] val,
                            output list_result_t r);
    int i;
    r = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        i = (op == OP_PUSH_FRONT) ? 0 : (op == OP_PUSH_BACK) ? list_len : int'(pos);
        if (list_len < Depth && i <= list_len) begin
          for (int k = list_len; k > i; k--) list_words[k] = list_words[k-1];
          list_words[i] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT, OP_REMOVE: begin
        i = (op == OP_POP_FRONT) ? 0 : int'(pos);
        if (i < list_len) begin
          if (op == OP_POP_FRONT) r.read_data = list_words[0];
          for (int k = i; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(pos) < list_len) begin
          r.read_data = list_words[pos];
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        r.ok = 1'b1;
        for (int k = 0; k < list_len; k++) begin
          if (!r.found && list_words[k] == val) begin
            r.found = 1'b1;
            r.found_index = k[5:0];
          end
        end
      end
      default: begin
        if (int'(pos) <= Depth) begin
          for (int k = list_len; k < int'(pos); k++) list_words[k] = '0;
          list_len = int'(pos);
          r.ok = 1'b1;
        end
      end
    endcase
    r.entry_count = list_len[6:0];
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  // Offers one request from the next falling edge and holds it until accepted.
  task automatic send_request(input op_e op, input logic [6:0] pos, input logic [31:0] val,
                              input bit typed, input list_result_t want);
    list_result_t r;
    @(negedge clk_i);
    s_axis_tdata  = {6'd0, val, pos, op};
    s_axis_tvalid = 1'b1;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    list_apply(op, pos, val, r);
    pending_results.insert(pending_results.size(), typed ? want : r);
    requests_sent++;
    op_hits[op]++;
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    list_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[46:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 32'(got.entry_count), 32'd0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
        if (got.found !== want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.found_index !== want.found_index)
          report_mismatch("found_index", 32'(got.found_index), 32'(want.found_index));
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      end
    end
  end

  // Receiver: random stall phases, quiet stretches, and one long hold-off.
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_left = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    if (rx_cycle >= 3000 && rx_cycle < 3600) m_axis_tready <= 1'b0;
    else if (rx_mode == 0) m_axis_tready <= 1'b1;
    else if (rx_mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  request_row_t table_rows [$];
  list_result_t none;

  function automatic list_result_t res(input logic ok, input logic [31:0] data,
                                       input logic [6:0] cnt);
    list_result_t r;
    r = '0;
    r.ok = ok;
    r.read_data = data;
    r.entry_count = cnt;
    return r;
  endfunction

  initial begin
    op_e         op;
    logic [6:0]  pos;
    logic [31:0] val;
    int          burst;
    none = '0;
    for (int k = 0; k < 8; k++) value_pool[k] = $urandom();
    // Requests on an empty list, then the ends of the value range, then range and full-list errors.
    table_rows = '{
      '{OP_POP_FRONT, 7'd0,   32'd0,        1'b1, res(1'b0, 32'd0, 7'd0)},
      '{OP_READ,      7'd0,   32'd0,        1'b1, res(1'b0, 32'd0, 7'd0)},
      '{OP_REMOVE,    7'd0,   32'd0,        1'b1, res(1'b0, 32'd0, 7'd0)},
      '{OP_FIND,      7'd0,   32'd5,        1'b1, res(1'b1, 32'd0, 7'd0)},
      '{OP_INSERT,    7'd1,   32'd9,        1'b1, res(1'b0, 32'd0, 7'd0)},
      '{OP_INSERT,    7'd0,   32'h7fffffff, 1'b1, res(1'b1, 32'd0, 7'd1)},
      '{OP_PUSH_BACK, 7'd0,   32'h80000000, 1'b1, res(1'b1, 32'd0, 7'd2)},
      '{OP_PUSH_FRONT,7'd0,   32'd0,        1'b1, res(1'b1, 32'd0, 7'd3)},
      '{OP_INSERT,    7'd3,   32'hffffffff, 1'b0, none},
      '{OP_READ,      7'd1,   32'd0,        1'b0, none},
      '{OP_FIND,      7'd0,   32'h80000000, 1'b0, none},
      '{OP_FIND,      7'd0,   32'h00012345, 1'b0, none},
      '{OP_REMOVE,    7'd0,   32'd0,        1'b0, none},
      '{OP_READ,      7'd127, 32'd0,        1'b1, res(1'b0, 32'd0, 7'd3)},
      '{OP_RESIZE,    7'd65,  32'd0,        1'b1, res(1'b0, 32'd0, 7'd3)},
      '{OP_RESIZE,    7'd127, 32'd0,        1'b1, res(1'b0, 32'd0, 7'd3)},
      '{OP_RESIZE,    7'd64,  32'd0,        1'b1, res(1'b1, 32'd0, 7'd64)},
      '{OP_PUSH_BACK, 7'd0,   32'd1,        1'b1, res(1'b0, 32'd0, 7'd64)},
      '{OP_PUSH_FRONT,7'd0,   32'd1,        1'b1, res(1'b0, 32'd0, 7'd64)},
      '{OP_INSERT,    7'd64,  32'd1,        1'b1, res(1'b0, 32'd0, 7'd64)},
      '{OP_FIND,      7'd0,   32'd0,        1'b0, none},
      '{OP_READ,      7'd63,  32'd0,        1'b1, res(1'b1, 32'd0, 7'd64)},
      '{OP_RESIZE,    7'd0,   32'd0,        1'b1, res(1'b1, 32'd0, 7'd0)},
      '{OP_POP_FRONT, 7'd0,   32'd0,        1'b1, res(1'b0, 32'd0, 7'd0)}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (table_rows[i])
      send_request(table_rows[i].op, table_rows[i].pos, table_rows[i].val,
                   table_rows[i].typed, table_rows[i].want);

    burst = 0;
    for (int n = 0; n < 900; n++) begin
      // Bias the operation towards pushes on a short list and pop, insert or remove on a long one.
      if ($urandom_range(0, 99) < 8) op = op_e'($urandom_range(0, 7));
      else if (list_len < 8) op = op_e'($urandom_range(0, 99) < 60 ? $urandom_range(0, 1)
                                                                   : $urandom_range(0, 7));
      else if (list_len > 56) op = op_e'($urandom_range(0, 99) < 50 ? $urandom_range(2, 4)
                                                                    : $urandom_range(0, 7));
      else op = op_e'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 15) pos = 7'($urandom_range(0, 127));
      else if (op == OP_RESIZE) pos = ($urandom_range(0, 9) == 0) ? 7'(Depth)
                                      : 7'($urandom_range(0, list_len + 4));
      else if (op == OP_INSERT || list_len == 0) pos = 7'($urandom_range(0, list_len));
      else pos = 7'($urandom_range(0, list_len - 1));
      val = ($urandom_range(0, 99) < 50) ? value_pool[$urandom_range(0, 7)] : $urandom();
      if (op == OP_FIND && list_len > 0 && $urandom_range(0, 1))
        val = list_words[$urandom_range(0, list_len - 1)];
      send_request(op, pos, val, 1'b0, none);
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end else begin
        burst--;
      end
      if (n == 450) begin
        idle_gap(1);
        while (pending_results.size() != 0) @(negedge clk_i);
      end
    end
    idle_gap(1);

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (pending_results.size() != 0) report_mismatch("missing items", 32'd0, 32'd0);
    $display("Ran %0d requests and checked %0d results across all eight operations.",
             requests_sent, results_seen);
    $display("Per operation: %0d %0d %0d %0d %0d %0d %0d %0d", op_hits[0], op_hits[1],
             op_hits[2], op_hits[3], op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
